>>> design/krt_pkg.sv
// Shared types, codes and defaults for the keyed record table.
package krt_pkg;

    localparam int KRT_SLOTS = 64;

    // Word field widths
    localparam int MODE_W  = 3;
    localparam int KEY_W   = 32;
    localparam int CNT_W   = 16;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = 6;
    localparam int SUM_W   = 22;
    localparam int FILL_W  = 7;
    localparam int REC_W   = KEY_W + CNT_W;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Command modes
    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FIND   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TOTAL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_REM_RD,
        S_REM_WR,
        S_FINISH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic              start;    // latch the input word, reset scan and result
        logic              scan;     // advance the table walk by one slot
        logic              add_wr;   // append record at the fill level
        logic              clear;    // empty the table
        logic              rd_last;  // read the last used record
        logic              rem_wr;   // move last record onto the matched slot
        logic              load_out; // load the result into the output register
        logic [STAT_W-1:0] status;   // status code for load_out
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;     // latched command mode
        logic              full;     // fill level has reached the slot count
        logic              hit;      // current scan data matches the key
        logic              scan_end; // every used slot has been seen
        logic              out_free; // output register can take a result
    } t_stat;

endpackage

>>> design/krt_ctrl.sv
// Command sequencer of the keyed record table.
module krt_ctrl
    import krt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the result status until the finished result is loaded.
    logic [STAT_W-1:0] r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= STAT_OK;
        end else begin
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_status    = STAT_OK;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.mode)
                    MODE_ADD: begin
                        if (i_stat.full) begin
                            n_status = STAT_FULL;
                        end else begin
                            o_cmd.add_wr = 1'b1;
                        end
                        n_state = S_FINISH;
                    end
                    MODE_REMOVE, MODE_FIND, MODE_TOTAL: begin
                        n_state = S_SCAN;
                    end
                    MODE_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_FINISH;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit) begin
                    n_state = (i_stat.mode == MODE_REMOVE) ? S_REM_RD : S_FINISH;
                end else if (i_stat.scan_end) begin
                    n_status = (i_stat.mode == MODE_TOTAL) ? STAT_OK : STAT_MISSING;
                    n_state  = S_FINISH;
                end
            end
            S_REM_RD: begin
                o_cmd.rd_last = 1'b1;
                n_state       = S_REM_WR;
            end
            S_REM_WR: begin
                o_cmd.rem_wr = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/krt_datapath.sv
// Record memory, fill counter, table walk and result register.
module krt_datapath
    import krt_pkg::*;
#(
    parameter int SLOTS = KRT_SLOTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [IN_DATA_W-1:0]  i_data,      // key[31:0], count_value[47:32]
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    // Latched command word
    logic [MODE_W-1:0] r_mode;
    logic [KEY_W-1:0]  r_key;
    logic [CNT_W-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode <= i_mode;
            r_key  <= i_data[KEY_W-1:0];
            r_cnt  <= i_data[KEY_W +: CNT_W];
        end
    end

    // Fill level
    logic [CW-1:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.clear) begin
            r_fill <= '0;
        end else if (i_cmd.add_wr) begin
            r_fill <= r_fill + 1'b1;
        end else if (i_cmd.rem_wr) begin
            r_fill <= r_fill - 1'b1;
        end
    end

    logic [CW-1:0] last_idx;
    assign last_idx = r_fill - 1'b1;

    // Record memory: {key, count}, one write and one registered read per cycle
    logic [REC_W-1:0] mem [0:SLOTS-1];
    logic [REC_W-1:0] r_rd_data;
    logic [CW-1:0]    r_rd_idx;
    logic [AW-1:0]    r_dat_idx;
    logic             r_dv;
    logic             rd_issue;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    r_slot;

    assign rd_issue = i_cmd.scan && (r_rd_idx < r_fill);
    assign rd_addr  = i_cmd.rd_last ? last_idx[AW-1:0] : r_rd_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_wr) begin
            mem[r_fill[AW-1:0]] <= {r_key, r_cnt};
        end else if (i_cmd.rem_wr) begin
            mem[r_slot] <= r_rd_data;
        end
        if (rd_issue || i_cmd.rd_last) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Table walk: one read issued per cycle, data checked in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_dv     <= 1'b0;
        end else if (i_cmd.start) begin
            r_rd_idx <= '0;
            r_dv     <= 1'b0;
        end else if (i_cmd.scan) begin
            r_dv <= rd_issue;
            if (rd_issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_dat_idx <= r_rd_idx[AW-1:0];
        end
    end

    logic hit;
    assign hit = i_cmd.scan && r_dv && (r_rd_data[REC_W-1:CNT_W] == r_key)
               && ((r_mode == MODE_FIND) || (r_mode == MODE_REMOVE));

    // Result fields gathered along the way
    logic [CNT_W-1:0] r_found;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W:0]   sum_add;

    assign sum_add = {1'b0, r_sum} + {{(SUM_W+1-CNT_W){1'b0}}, r_rd_data[CNT_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_slot  <= '0;
            r_found <= '0;
            r_sum   <= '0;
        end else begin
            if (i_cmd.add_wr) begin
                r_slot <= r_fill[AW-1:0];
            end
            if (hit) begin
                r_slot <= r_dat_idx;
                if (r_mode == MODE_FIND) begin
                    r_found <= r_rd_data[CNT_W-1:0];
                end
            end
            if (i_cmd.scan && r_dv && (r_mode == MODE_TOTAL)) begin
                // saturate the running sum
                r_sum <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
            end
        end
    end

    // Output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [AW+SLOT_W-1:0]  slot_ext;
    logic [CW+FILL_W-1:0]  fill_ext;

    assign slot_ext = {{SLOT_W{1'b0}}, r_slot};
    assign fill_ext = {{FILL_W{1'b0}}, r_fill};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {{(OUT_DATA_W-STAT_W-SLOT_W-CNT_W-SUM_W-FILL_W){1'b0}},
                           fill_ext[FILL_W-1:0], r_sum, r_found,
                           slot_ext[SLOT_W-1:0], i_cmd.status};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_stat.mode     = r_mode;
    assign o_stat.full     = (r_fill >= SLOTS_C);
    assign o_stat.hit      = hit;
    assign o_stat.scan_end = !r_dv && (r_rd_idx >= r_fill);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

>>> design/keyed_record_table_unit.sv
// Top level of the keyed record table: command stream in, result stream out.
//
// A dense table of up to SLOTS records, each a 32-bit signed key with a 16-bit
// count, kept in slots 0 up to the fill level with no gaps. Every input word
// is one command, chosen by the mode in s_axis_tuser: add appends a record at
// the fill level (status full when no slot is left), find returns the lowest
// matching slot and its count, remove moves the last record onto the lowest
// match and shrinks the table, total sums all stored counts saturating at the
// top of its 22-bit field, and clear empties the table. Unused modes do
// nothing and report ok. Each command yields exactly one result word on
// m_axis carrying the status, slot, found count, sum and fill level after
// the command. Commands run one at a time; find, total and remove walk the
// record memory through its single registered read port, one slot per
// cycle. A finished result waits in the output register, and the next
// command word is taken while it waits.
// The record memory is not cleared at reset; only slots below the fill level
// are ever read.
module keyed_record_table_unit
    import krt_pkg::*;
#(
    parameter int SLOTS = KRT_SLOTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // key[31:0], count_value[47:32]
    input  logic [MODE_W-1:0]     s_axis_tuser,  // mode[2:0]
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // status[1:0], slot_index[7:2],
                                                 // found_count[23:8],
                                                 // count_sum[45:24],
                                                 // fill_level[52:46], zero[55:53]
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer: decodes the mode and steps the walk
    krt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath: record memory, fill level, sum and output register
    krt_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_mode      (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

>>> tb/tb_top.sv
// Self-checking stream testbench for the keyed record table unit.
`timescale 1ns / 1ps

module tb_top;
    import krt_pkg::*;

    // Result word layout, status in the lowest bits
    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]  found;
        logic [SLOT_W-1:0] slot;
        logic [STAT_W-1:0] status;
    } t_krt_result;

    localparam int RES_W = $bits(t_krt_result);
    localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = MODE_CLEAR + 1'b1;
    localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = {MODE_W{1'b1}};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // key[31:0], count_value[47:32]
    logic [MODE_W-1:0]     s_axis_tuser = '0;  // mode[2:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;       // status, slot_index, found_count,
                                               // count_sum, fill_level, zero pad

    keyed_record_table_unit #(
        .SLOTS(KRT_SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow copy of the record table
    logic [KEY_W-1:0]  table_keys   [KRT_SLOTS];
    logic [CNT_W-1:0]  table_counts [KRT_SLOTS];
    logic [FILL_W-1:0] table_fill;

    t_krt_result pending_results[$];
    t_krt_result got_word;
    t_krt_result want_word;
    int          err_count = 0;
    bit          idle_en   = 1'b1;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // Apply one command to the shadow table and return the result it yields
    function automatic t_krt_result predict_table_cmd(input logic [MODE_W-1:0] mode,
                                                      input logic [KEY_W-1:0]  key,
                                                      input logic [CNT_W-1:0]  cnt);
        t_krt_result   res;
        int            hit;
        int            i;
        logic [SUM_W:0] acc;
        res = '0;
        hit = -1;
        acc = '0;
        // lowest matching slot wins on duplicates
        for (i = int'(table_fill) - 1; i >= 0; i--)
            if (table_keys[i] == key) hit = i;
        case (mode)
            MODE_ADD: begin
                if (table_fill >= KRT_SLOTS) begin
                    res.status = STAT_FULL;
                end else begin
                    res.slot = table_fill[SLOT_W-1:0];
                    table_keys[table_fill]   = key;
                    table_counts[table_fill] = cnt;
                    table_fill++;
                end
            end
            MODE_REMOVE: begin
                if (hit < 0) begin
                    res.status = STAT_MISSING;
                end else begin
                    // move the last record into the hole, then shrink
                    res.slot = SLOT_W'(hit);
                    table_keys[hit]   = table_keys[table_fill - 1];
                    table_counts[hit] = table_counts[table_fill - 1];
                    table_fill--;
                end
            end
            MODE_FIND: begin
                if (hit < 0) begin
                    res.status = STAT_MISSING;
                end else begin
                    res.slot  = SLOT_W'(hit);
                    res.found = table_counts[hit];
                end
            end
            MODE_TOTAL: begin
                for (i = 0; i < int'(table_fill); i++) begin
                    acc += table_counts[i];
                    if (acc > SUM_MAX) acc = SUM_MAX;
                end
                res.sum = acc[SUM_W-1:0];
            end
            MODE_CLEAR: table_fill = '0;
            default: ;
        endcase
        res.fill = table_fill;
        return res;
    endfunction

    // Idle length: mostly short, a few long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(40, 200);
    endfunction

    // Send one command word; record its expected result on acceptance
    task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                            input logic [CNT_W-1:0] cnt);
        int gap;
        gap = (!idle_en || $urandom_range(99) < 65) ? 0 : pick_idle();
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {cnt, key};
        s_axis_tuser  = mode;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_table_cmd(mode, key, cnt));
    endtask

    // Hold the command stream until every outstanding result has arrived
    task automatic wait_results_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Result stream receiver with random back-pressure
    initial begin : result_sink
        int hold;
        hold = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                m_axis_tready = 1'b0;
                hold--;
            end else begin
                m_axis_tready = 1'b1;
                if (idle_en && $urandom_range(99) < 15) hold = pick_idle();
            end
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want_word = pending_results.pop_front();
                got_word  = m_axis_tdata[RES_W-1:0];
                check_field("status",      32'(got_word.status), 32'(want_word.status));
                check_field("slot_index",  32'(got_word.slot),   32'(want_word.slot));
                check_field("found_count", 32'(got_word.found),  32'(want_word.found));
                check_field("count_sum",   32'(got_word.sum),    32'(want_word.sum));
                check_field("fill_level",  32'(got_word.fill),   32'(want_word.fill));
                check_field("pad", 32'(m_axis_tdata[OUT_DATA_W-1:RES_W]), 32'd0);
            end
        end
    end

    // Extreme keys, duplicates, misses, last-record remove, unused modes, empty table
    task automatic test_directed();
        send_cmd(MODE_TOTAL,  32'h0, 16'h0);
        send_cmd(MODE_FIND,   32'h0, 16'h0);
        send_cmd(MODE_REMOVE, 32'h0, 16'hFFFF);
        send_cmd(MODE_ADD,    32'h8000_0000, 16'h0000);
        send_cmd(MODE_ADD,    32'h7FFF_FFFF, 16'hFFFF);
        send_cmd(MODE_ADD,    32'hFFFF_FFFF, 16'h0001);
        send_cmd(MODE_ADD,    32'h8000_0000, 16'h1234);
        send_cmd(MODE_FIND,   32'h8000_0000, 16'h0);
        send_cmd(MODE_FIND,   32'h7FFF_FFFF, 16'h0);
        send_cmd(MODE_FIND,   32'h0, 16'h0);
        send_cmd(MODE_TOTAL,  32'hFFFF_FFFF, 16'hFFFF);
        send_cmd(MODE_REMOVE, 32'h8000_0000, 16'h0);
        send_cmd(MODE_FIND,   32'h8000_0000, 16'h0);
        send_cmd(MODE_REMOVE, 32'hFFFF_FFFF, 16'h0);
        send_cmd(MODE_REMOVE, 32'h1234_5678, 16'h0);
        for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++)
            send_cmd(MODE_W'(m), $urandom, 16'($urandom));
        send_cmd(MODE_TOTAL,  32'h0, 16'h0);
        send_cmd(MODE_CLEAR,  32'h7FFF_FFFF, 16'h0);
        send_cmd(MODE_FIND,   32'h7FFF_FFFF, 16'h0);
        send_cmd(MODE_TOTAL,  32'h0, 16'h0);
    endtask

    // Fill every slot with the largest count, then overflow, sum and refill
    task automatic test_full_table();
        send_cmd(MODE_CLEAR, 32'h0, 16'h0);
        for (int i = 0; i < KRT_SLOTS; i++)
            send_cmd(MODE_ADD, ((i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555) ^ i, 16'hFFFF);
        send_cmd(MODE_ADD,    32'h0, 16'h1);
        send_cmd(MODE_TOTAL,  32'h0, 16'h0);
        send_cmd(MODE_FIND,   32'hAAAA_AAAA ^ (KRT_SLOTS - 1), 16'h0);
        send_cmd(MODE_REMOVE, 32'h5555_5555, 16'h0);
        send_cmd(MODE_FIND,   32'hAAAA_AAAA ^ (KRT_SLOTS - 1), 16'h0);
        send_cmd(MODE_ADD,    32'h0, 16'h7);
        send_cmd(MODE_ADD,    32'h1, 16'h8);
        send_cmd(MODE_TOTAL,  32'h0, 16'h0);
        send_cmd(MODE_CLEAR,  32'h0, 16'h0);
    endtask

    // Random commands in alternating grow and shrink phases; keys mostly hit
    task automatic test_random_mix(input int n_items, input bit drain_midway);
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        int                r;
        bit                grow;
        for (int n = 0; n < n_items; n++) begin
            grow = ((n / 200) % 2) == 0;
            r = $urandom_range(99);
            if (r < (grow ? 50 : 15))      mode = MODE_ADD;
            else if (r < (grow ? 62 : 60)) mode = MODE_REMOVE;
            else if (r < 85)               mode = MODE_FIND;
            else if (r < 95)               mode = MODE_TOTAL;
            else if (r < 97)               mode = MODE_CLEAR;
            else mode = MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
            r = $urandom_range(99);
            if (r < 60 && table_fill != 0)
                key = table_keys[$urandom_range(int'(table_fill) - 1)];
            else if (r < 70)
                case ($urandom_range(3))
                    0: key = 32'h8000_0000;
                    1: key = 32'h7FFF_FFFF;
                    2: key = 32'h0;
                    default: key = 32'hFFFF_FFFF;
                endcase
            else
                key = $urandom;
            send_cmd(mode, key, 16'($urandom));
            if (drain_midway && n == n_items / 2) wait_results_drained();
        end
    endtask

    initial begin
        for (int i = 0; i < KRT_SLOTS; i++) begin
            table_keys[i]   = '0;
            table_counts[i] = '0;
        end
        table_fill = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_full_table();
        test_random_mix(1800, 1'b1);
        // a stretch with no idling on either side
        idle_en = 1'b0;
        test_random_mix(200, 1'b0);
        idle_en = 1'b1;

        wait_results_drained();
        repeat (100) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
